@@ rtl/core/mcswd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcswd_pkg : shared types and codes for the multi-channel soft watchdog
// Transaction structs, command codes, result kinds and the table write request.
// ----------------------------------------------------------------------------
package mcswd_pkg;

  // command codes
  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_REG    = 3'd1;
  localparam logic [2:0] FUNC_UNREG  = 3'd2;
  localparam logic [2:0] FUNC_FEED   = 3'd3;
  localparam logic [2:0] FUNC_CHECK  = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_DONE    = 2'd0;
  localparam logic [1:0] KIND_INVALID = 2'd1;
  localparam logic [1:0] KIND_EXPIRED = 2'd2;
  localparam logic [1:0] KIND_KICK    = 2'd3;

  // most results one check may give
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  channel;
    logic [31:0] period;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] channel_out;
    logic       last;
  } result_t;

  typedef struct packed {
    logic        per_en;
    logic        fed_en;
    logic [7:0]  addr;
    logic [31:0] per;
    logic [31:0] fed;
  } tbl_wr_t;

endpackage

@@ rtl/core/mcswd_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcswd_table : channel period and feed-time storage
// Two simple dual-port memories with registered reads; period entries carry valid
// bits so an unwritten channel reads as inactive.
// ----------------------------------------------------------------------------
module mcswd_table #(
  parameter int unsigned NUM_CHANNELS = 16,
  parameter int unsigned IDX_W        = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mcswd_pkg::tbl_wr_t   wr,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output logic [31:0]          rd_period,
  output logic [31:0]          rd_fed
);
  import mcswd_pkg::*;

  logic [31:0]             per_mem [NUM_CHANNELS];
  logic [31:0]             fed_mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld;
  logic [31:0]             per_rd;
  logic                    vld_rd;
  logic [IDX_W-1:0]        wr_idx;

  assign wr_idx = wr.addr[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (wr.per_en) begin
      per_mem[wr_idx] <= wr.per;
    end
    if (wr.fed_en) begin
      fed_mem[wr_idx] <= wr.fed;
    end
    if (rd_en) begin
      per_rd <= per_mem[rd_addr];
      rd_fed <= fed_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      vld_rd <= 1'b0;
    end else begin
      if (wr.per_en) begin
        vld[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        vld_rd <= vld[rd_addr];
      end
    end
  end

  // unwritten entry counts as period zero (inactive)
  assign rd_period = vld_rd ? per_rd : 32'd0;

endmodule

@@ rtl/core/mcswd_cmp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcswd_cmp : shared expiry compare unit
// Wrapping elapsed time against the channel period, one channel per cycle.
// ----------------------------------------------------------------------------
module mcswd_cmp (
  input  logic [31:0] now_ms,
  input  logic [31:0] fed_at,
  input  logic [31:0] period,
  output logic        expired
);
  import mcswd_pkg::*;

  logic [31:0] elapsed;

  assign elapsed = now_ms - fed_at;
  assign expired = (period != 32'd0) && (elapsed > period);

endmodule

@@ rtl/core/multi_channel_soft_watchdog.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_soft_watchdog : software watchdog channel multiplexer
// Tick, register, unregister and feed transactions give one result in the
// cycle after acceptance and leave busy low; a check scans the channel table.
// Check: busy for the whole scan, with one table read per cycle through
//   the shared compare unit; results appear during and at the end of the scan.
// Results are strobed for one cycle; the receiver cannot stall them.
// Reset (rst, synchronous): time counter zero, all channels inactive, idle.
// ----------------------------------------------------------------------------
module multi_channel_soft_watchdog #(
  parameter int unsigned NUM_CHANNELS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  mcswd_pkg::cmd_t     cmd,
  output logic                result_valid,
  output mcswd_pkg::result_t  result
);
  import mcswd_pkg::*;

  localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_CHANNELS + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_CHANNELS);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t               state;
  logic [31:0]          now_ms;

  // scan sequencer: read stage then compare stage
  logic [CNT_W-1:0]     rd_cnt;      // channels whose read has been issued
  logic                 chk_vld;     // table data valid for the compare
  logic [IDX_W-1:0]     chk_ch;
  // one expired result is held back so that 'last' can be set on the final one
  logic                 pend_vld;
  logic [IDX_W-1:0]     pend_ch;
  logic [RES_CNT_W-1:0] n_cnt;

  logic                 accept;
  logic                 ch_bad;
  logic                 rd_en;
  logic                 rd_done;
  tbl_wr_t              tbl_wr;
  logic [31:0]          rd_period;
  logic [31:0]          rd_fed;
  logic                 expired;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign ch_bad  = ({1'b0, cmd.channel} >= 9'(NUM_CHANNELS));
  assign rd_done = (rd_cnt == LAST_CNT);
  assign rd_en   = (state == S_SCAN) && !rd_done;

  // table writes happen at the accepting edge; a channel out of range writes nothing
  always_comb begin
    tbl_wr.per_en = 1'b0;
    tbl_wr.fed_en = 1'b0;
    tbl_wr.addr   = cmd.channel;
    tbl_wr.per    = cmd.period;
    tbl_wr.fed    = now_ms;
    if (accept && !ch_bad) begin
      case (cmd.func)
        FUNC_REG: begin
          tbl_wr.per_en = 1'b1;
          tbl_wr.fed_en = 1'b1;
        end
        FUNC_UNREG: begin
          tbl_wr.per_en = 1'b1;
          tbl_wr.per    = 32'd0;
        end
        FUNC_FEED: begin
          tbl_wr.fed_en = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  mcswd_table #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .IDX_W        (IDX_W)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .wr        (tbl_wr),
    .rd_en     (rd_en),
    .rd_addr   (rd_cnt[IDX_W-1:0]),
    .rd_period (rd_period),
    .rd_fed    (rd_fed)
  );

  mcswd_cmp u_cmp (
    .now_ms  (now_ms),
    .fed_at  (rd_fed),
    .period  (rd_period),
    .expired (expired)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      now_ms       <= 32'd0;
      rd_cnt       <= '0;
      chk_vld      <= 1'b0;
      pend_vld     <= 1'b0;
      n_cnt        <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            case (cmd.func)
              FUNC_TICK: begin
                now_ms       <= now_ms + 32'd1;
                result_valid <= 1'b1;
                result       <= '{kind: KIND_DONE, channel_out: 8'd0, last: 1'b1};
              end
              FUNC_REG, FUNC_UNREG, FUNC_FEED: begin
                result_valid <= 1'b1;
                result       <= '{kind: ch_bad ? KIND_INVALID : KIND_DONE,
                                  channel_out: cmd.channel, last: 1'b1};
              end
              FUNC_CHECK: begin
                state    <= S_SCAN;
                rd_cnt   <= '0;
                chk_vld  <= 1'b0;
                pend_vld <= 1'b0;
                n_cnt    <= '0;
              end
              default: begin
                // unused codes: no state change, no result
              end
            endcase
          end
        end
        S_SCAN: begin
          // read stage
          chk_vld <= !rd_done;
          chk_ch  <= rd_cnt[IDX_W-1:0];
          if (!rd_done) begin
            rd_cnt <= rd_cnt + CNT_W'(1);
          end
          // compare stage: release the held result when a newer one turns up
          if (chk_vld && expired && (n_cnt < RES_CNT_W'(MAX_RESULTS))) begin
            if (pend_vld) begin
              result_valid <= 1'b1;
              result       <= '{kind: KIND_EXPIRED, channel_out: 8'(pend_ch), last: 1'b0};
            end
            pend_vld <= 1'b1;
            pend_ch  <= chk_ch;
            n_cnt    <= n_cnt + RES_CNT_W'(1);
          end
          // scan over: final expired result, or the hardware kick
          if (rd_done && !chk_vld) begin
            result_valid <= 1'b1;
            if (pend_vld) begin
              result <= '{kind: KIND_EXPIRED, channel_out: 8'(pend_ch), last: 1'b1};
            end else begin
              result <= '{kind: KIND_KICK, channel_out: 8'd0, last: 1'b1};
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/mcswd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcswd_checker : port-level checks for the soft watchdog
// Watches command and result transactions on the top level's ports.
// ----------------------------------------------------------------------------
module mcswd_checker #(
  parameter int unsigned NUM_CHANNELS = 16
) (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input mcswd_pkg::cmd_t     cmd,
  input logic                result_valid,
  input mcswd_pkg::result_t  result
);
  import mcswd_pkg::*;

  logic acc;
  logic acc_single;
  logic ch_bad;

  assign acc        = start && !busy;
  assign acc_single = acc && (cmd.func == FUNC_REG || cmd.func == FUNC_UNREG ||
                              cmd.func == FUNC_FEED);
  assign ch_bad     = ({1'b0, cmd.channel} >= 9'(NUM_CHANNELS));

  a_tick_done: assert property (@(posedge clk) disable iff (rst)
    acc && cmd.func == FUNC_TICK |=> result_valid && result.kind == KIND_DONE &&
      result.channel_out == 8'd0 && result.last)
    else $error("tick transaction without a done result");

  a_bad_channel: assert property (@(posedge clk) disable iff (rst)
    acc_single && ch_bad |=> result_valid && result.kind == KIND_INVALID &&
      result.channel_out == $past(cmd.channel))
    else $error("out-of-range channel not reported");

  a_check_busy: assert property (@(posedge clk) disable iff (rst)
    acc && cmd.func == FUNC_CHECK |=> busy && !result_valid)
    else $error("check transaction did not start a scan");

  a_kick_form: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == KIND_KICK |-> result.last &&
      result.channel_out == 8'd0)
    else $error("malformed kick result");

endmodule

bind multi_channel_soft_watchdog mcswd_checker #(
  .NUM_CHANNELS (NUM_CHANNELS)
) u_mcswd_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .cmd          (cmd),
  .result_valid (result_valid),
  .result       (result)
);
